/* hw/rtl/dbd_pkg.sv */
// types, constants, microcode table and calendar tables for the days-between-dates counter
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

	// field widths
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;

	// day serial accumulator, wide enough for 365 * 16383 plus leap and month days
	localparam int ACC_W = 23;

	// divide by 100 as multiply by reciprocal: q = (y * 5243) >> 19, exact below 16384
	localparam int RECIP_W     = 13;
	localparam int PROD_W      = YEAR_W + RECIP_W;
	localparam int RECIP_SHIFT = 19;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
	localparam logic [YEAR_W-1:0]  CENTURY   = YEAR_W'(100);

	localparam logic [ACC_W-1:0]   DAYS_PER_YEAR = ACC_W'(365);
	localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	// microcode step addresses
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] STEP_YEAR   = PC_W'(0);
	localparam logic [PC_W-1:0] STEP_LEAP   = PC_W'(1);
	localparam logic [PC_W-1:0] STEP_LEAPS  = PC_W'(2);
	localparam logic [PC_W-1:0] STEP_MDAY   = PC_W'(3);
	localparam logic [PC_W-1:0] STEP_FINISH = PC_W'(4);

	// request and response payloads
	typedef struct packed {
		logic [YEAR_W-1:0]  start_year;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   start_day;
		logic [YEAR_W-1:0]  end_year;
		logic [MONTH_W-1:0] end_month;
		logic [DAY_W-1:0]   end_day;
	} dbd_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic               order_error;
	} dbd_rsp_t;

	// sequencer state
	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} dbd_seq_t;

	// control word fields
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_YEAR,
		MUL_PRIOR
	} dbd_mul_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_YEAR,
		ACC_LEAPS,
		ACC_MDAY
	} dbd_acc_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_IF_START,
		JMP_END
	} dbd_jmp_t;

	typedef struct packed {
		dbd_mul_t          mul;
		dbd_acc_t          acc;
		logic              leap_en;
		logic              save_start;
		dbd_jmp_t          jmp;
		logic [PC_W-1:0]   target;
	} dbd_ucode_t;

	// microprogram: one pass per date, start date first, then compare
	function automatic dbd_ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		dbd_ucode_t w;
		w = '{mul: MUL_NONE, acc: ACC_HOLD, leap_en: 1'b0, save_start: 1'b0,
			jmp: JMP_END, target: STEP_YEAR};
		unique case (pc)
			STEP_YEAR: begin
				w.mul = MUL_YEAR;
				w.acc = ACC_YEAR;
				w.jmp = JMP_NEXT;
			end
			STEP_LEAP: begin
				w.mul     = MUL_PRIOR;
				w.leap_en = 1'b1;
				w.jmp     = JMP_NEXT;
			end
			STEP_LEAPS: begin
				w.acc = ACC_LEAPS;
				w.jmp = JMP_NEXT;
			end
			STEP_MDAY: begin
				w.acc        = ACC_MDAY;
				w.save_start = 1'b1;
				w.jmp        = JMP_IF_START;
				w.target     = STEP_YEAR;
			end
			STEP_FINISH: begin
				w.jmp = JMP_END;
			end
			default: begin
				w.jmp = JMP_END;
			end
		endcase
		return w;
	endfunction

	// days in the year before the first of a month (month already clamped)
	function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// length of a month, february depending on the leap flag
	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd2:                    r = leap ? DAY_W'(29) : DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11: r = DAY_W'(30);
			default:                 r = DAY_W'(31);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/days_between_dates_counter_core.sv */
// days between two gregorian dates, closed-form serial difference driven by a microcode table
`timescale 1ns / 1ps
`default_nettype none

// Takes a start and an end date and returns the number of days from one to the other.
// Each date is turned into a day serial counted from year 0 (365 per year plus leap days,
// days before the month and the day itself); the result is the difference, saturating at
// the 22-bit maximum. A start date after the end date gives order_error with a count of
// zero. Month 0 reads as January, months above 12 as December, day 0 as the first and a
// day past the month's end as its last day. An item runs from its transfer through nine
// microcode steps, four per date and one compare. The four steps per date are set by the
// one shared reciprocal multiplier, which the program runs twice per date (year and
// year - 1). The compare step waits for as long as an earlier result is still stalled in
// the output register. A finished result waits in the output register while the next
// item is taken, so a new item can start before the last result is collected.
module days_between_dates_counter_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  dbd_pkg::dbd_req_t   req_data,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output dbd_pkg::dbd_rsp_t   rsp_data
);

	import dbd_pkg::*;

	// control registers
	dbd_seq_t         state_q, state_d;
	logic [PC_W-1:0]  pc_q, pc_d;
	logic             side_q, side_d;
	logic             rsp_valid_q;

	// datapath registers
	dbd_req_t           req_q;
	logic [PROD_W-1:0]  prod_q;
	logic               leap_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   start_serial_q;
	dbd_rsp_t           rsp_q;

	dbd_ucode_t uc;
	logic       req_xfer;
	logic       rsp_free;
	logic       run;
	logic       finish;

	// operand selection for the current date
	logic [YEAR_W-1:0]  sel_year;
	logic [YEAR_W-1:0]  prior_year;
	logic [MONTH_W-1:0] raw_month;
	logic [DAY_W-1:0]   raw_day;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   mlen;
	logic [DAY_W-1:0]   day;

	logic [QUOT_W-1:0]  quot100;
	logic [YEAR_W-1:0]  hundreds;
	logic               leap_d;
	logic [PROD_W-1:0]  mul_op;
	logic [ACC_W-1:0]   leaps;
	logic [ACC_W-1:0]   mday;
	logic [ACC_W-1:0]   acc_d;

	logic               order_err;
	logic [ACC_W-1:0]   diff;
	logic [COUNT_W-1:0] count_sat;

	assign uc        = ucode_rom(pc_q);
	assign req_stall = (state_q != SEQ_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign run       = (state_q == SEQ_RUN);
	assign finish    = run && (uc.jmp == JMP_END) && rsp_free;

	// pick the date of the current pass and clamp month and day
	always_comb begin
		sel_year   = side_q ? req_q.end_year  : req_q.start_year;
		raw_month  = side_q ? req_q.end_month : req_q.start_month;
		raw_day    = side_q ? req_q.end_day   : req_q.start_day;
		prior_year = sel_year - YEAR_W'(1);
		if (raw_month == '0) begin
			month = MONTH_JAN;
		end else if (raw_month > MONTH_DEC) begin
			month = MONTH_DEC;
		end else begin
			month = raw_month;
		end
		mlen = month_length(month, leap_q);
		if (raw_day == '0) begin
			day = DAY_W'(1);
		end else if (raw_day > mlen) begin
			day = mlen;
		end else begin
			day = raw_day;
		end
	end

	// leap test from the registered quotient by 100
	always_comb begin
		quot100  = prod_q[PROD_W-1:RECIP_SHIFT];
		hundreds = YEAR_W'(quot100) * CENTURY;
		leap_d   = (sel_year[1:0] == 2'b00) &&
			((sel_year != hundreds) || (quot100[1:0] == 2'b00));
	end

	// reciprocal multiplier operand
	always_comb begin
		unique case (uc.mul)
			MUL_YEAR:  mul_op = PROD_W'(sel_year);
			MUL_PRIOR: mul_op = PROD_W'(prior_year);
			default:   mul_op = '0;
		endcase
	end

	// accumulator update
	always_comb begin
		if (sel_year == '0) begin
			leaps = '0;
		end else begin
			leaps = ACC_W'(prior_year[YEAR_W-1:2]) - ACC_W'(quot100)
				+ ACC_W'(quot100[QUOT_W-1:2]) + ACC_W'(1);
		end
		mday = ACC_W'(days_before_month(month)) + ACC_W'(day)
			+ ACC_W'((month > MONTH_FEB) && leap_q);
		unique case (uc.acc)
			ACC_YEAR:  acc_d = ACC_W'(sel_year) * DAYS_PER_YEAR;
			ACC_LEAPS: acc_d = acc_q + leaps;
			ACC_MDAY:  acc_d = acc_q + mday;
			default:   acc_d = acc_q;
		endcase
	end

	// compare serials and saturate the count
	always_comb begin
		order_err = (start_serial_q > acc_q);
		diff      = acc_q - start_serial_q;
		if (order_err) begin
			count_sat = '0;
		end else if (diff > ACC_W'(COUNT_MAX)) begin
			count_sat = COUNT_MAX;
		end else begin
			count_sat = diff[COUNT_W-1:0];
		end
	end

	// sequencer next state, step counter and side select
	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		side_d  = side_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (req_xfer) begin
					state_d = SEQ_RUN;
					pc_d    = STEP_YEAR;
					side_d  = 1'b0;
				end
			end
			SEQ_RUN: begin
				unique case (uc.jmp)
					JMP_NEXT: begin
						pc_d = pc_q + PC_W'(1);
					end
					JMP_IF_START: begin
						side_d = !side_q;
						pc_d   = !side_q ? uc.target : pc_q + PC_W'(1);
					end
					default: begin
						if (rsp_free) begin
							state_d = SEQ_IDLE;
							pc_d    = STEP_YEAR;
						end
					end
				endcase
			end
			default: begin
				state_d = SEQ_IDLE;
				pc_d    = STEP_YEAR;
			end
		endcase
	end

	// control state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			pc_q        <= STEP_YEAR;
			side_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			side_q  <= side_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_q <= req_data;
		end
		if (run && (uc.mul != MUL_NONE)) begin
			prod_q <= mul_op * PROD_W'(RECIP_100);
		end
		if (run && uc.leap_en) begin
			leap_q <= leap_d;
		end
		if (run) begin
			acc_q <= acc_d;
		end
		if (run && uc.save_start && !side_q) begin
			start_serial_q <= acc_d;
		end
		if (finish) begin
			rsp_q.day_count   <= count_sat;
			rsp_q.order_error <= order_err;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// both date passes are done when the compare step is reached, which may wait there
	a_finish_after_both: assert property (@(posedge clk) disable iff (!arst_n)
		(run && (pc_q == STEP_FINISH)) |-> !side_q &&
			(($past(pc_q, 1) == STEP_MDAY) || ($past(pc_q, 1) == STEP_FINISH)))
		else $error("compare step reached without both date passes");

	// idle sequencer always parks at the first step
	a_idle_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_IDLE) |-> (pc_q == STEP_YEAR) && !side_q)
		else $error("idle sequencer not parked at the first step");

	// a transfer on the request side starts the program
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> run && (pc_q == STEP_YEAR))
		else $error("request transfer did not start the program");

	// an order error always carries a zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.order_error) |-> (rsp_data.day_count == '0))
		else $error("order error with a non-zero count");

	// a new result appears only from the compare step
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(run && (pc_q == STEP_FINISH), 1))
		else $error("result without a compare step");

endmodule

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for the days-between-dates counter core
`timescale 1ns / 1ps

module tb;

	import dbd_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned RANDOM_ITEMS   = 100;
	localparam int unsigned TAIL_CYCLES    = 20;

	// gregorian leap rule
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
		case (m)
			2:           return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// day number counted from the start of year 0, month and day pulled into range first
	function automatic int unsigned day_serial(input logic [YEAR_W-1:0] y_in,
			input logic [MONTH_W-1:0] m_in, input logic [DAY_W-1:0] d_in);
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned p;
		int unsigned s;
		int unsigned k;
		bit          lp;
		y  = y_in;
		m  = m_in;
		d  = d_in;
		lp = leap_year(y);
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (d < 1) d = 1;
		if (d > days_in_month(m, lp)) d = days_in_month(m, lp);
		s = 365 * y + d;
		// year 0 is itself a leap year, so every later year gets one extra
		if (y > 0) begin
			p = y - 1;
			s += p / 4 - p / 100 + p / 400 + 1;
		end
		for (k = 1; k < m; k++) s += days_in_month(k, lp);
		return s;
	endfunction

	// expected response for one pair of dates
	function automatic dbd_rsp_t predict_gap(input dbd_req_t r);
		dbd_rsp_t    res;
		int unsigned from_day;
		int unsigned to_day;
		from_day = day_serial(r.start_year, r.start_month, r.start_day);
		to_day   = day_serial(r.end_year, r.end_month, r.end_day);
		res.order_error = (from_day > to_day);
		if (res.order_error)
			res.day_count = '0;
		else if (to_day - from_day > COUNT_MAX)
			res.day_count = COUNT_MAX;
		else
			res.day_count = COUNT_W'(to_day - from_day);
		return res;
	endfunction

	function automatic dbd_req_t date_pair(input int unsigned sy, input int unsigned sm,
			input int unsigned sd, input int unsigned ey, input int unsigned em,
			input int unsigned ed);
		dbd_req_t r;
		r.start_year  = YEAR_W'(sy);
		r.start_month = MONTH_W'(sm);
		r.start_day   = DAY_W'(sd);
		r.end_year    = YEAR_W'(ey);
		r.end_month   = MONTH_W'(em);
		r.end_day     = DAY_W'(ed);
		return r;
	endfunction

	// random date pairs: mostly real dates close together, some raw bit noise
	function automatic dbd_req_t random_dates();
		dbd_req_t    r;
		int unsigned kind;
		int unsigned y;
		int unsigned m;
		int unsigned ey;
		int unsigned em;
		kind = $urandom_range(0, 99);
		y    = $urandom_range(1, 9999);
		m    = $urandom_range(1, 12);
		r = date_pair(y, m, $urandom_range(1, days_in_month(m, leap_year(y))), y, m, 1);
		if (kind < 20) begin
			// any bit pattern, out-of-range fields included
			r = date_pair($urandom_range(0, 16383), $urandom_range(0, 15),
				$urandom_range(0, 31), $urandom_range(0, 16383), $urandom_range(0, 15),
				$urandom_range(0, 31));
		end else if (kind < 90) begin
			if (kind < 60)
				ey = y + $urandom_range(0, 3);
			else if (kind < 80)
				ey = y;
			else
				ey = (y > 3) ? y - $urandom_range(0, 3) : y;
			em = (kind >= 60 && kind < 70) ? m : $urandom_range(1, 12);
			r.end_year  = YEAR_W'(ey);
			r.end_month = MONTH_W'(em);
			r.end_day   = DAY_W'($urandom_range(1, days_in_month(em, leap_year(ey))));
		end else begin
			// around the end of february in century and leap years
			y = $urandom_range(0, 1) ? 100 * $urandom_range(0, 99)
				: 4 * $urandom_range(0, 2499);
			r = date_pair(y, 2, $urandom_range(27, 31), y, $urandom_range(2, 3),
				$urandom_range(1, 31));
		end
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// queue of expected day counts, checked in order
	class day_count_board;
		dbd_rsp_t    due_q[$];
		int unsigned fails;

		function new();
			fails = 0;
		endfunction

		function int unsigned pending();
			return due_q.size();
		endfunction

		function void note_dates(input dbd_req_t r);
			due_q.push_back(predict_gap(r));
		endfunction

		function void check_count(input dbd_rsp_t got);
			dbd_rsp_t want;
			if (due_q.size() == 0) begin
				$display("%0t unexpected result: expected none, got day_count %0d order_error %0b",
					$time, got.day_count, got.order_error);
				fails++;
				return;
			end
			want = due_q.pop_front();
			if (got.day_count !== want.day_count) begin
				$display("%0t day_count mismatch: expected %0d, got %0d",
					$time, want.day_count, got.day_count);
				fails++;
			end
			if (got.order_error !== want.order_error) begin
				$display("%0t order_error mismatch: expected %0b, got %0b",
					$time, want.order_error, got.order_error);
				fails++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	dbd_req_t req_data;
	logic     rsp_valid;
	logic     rsp_stall;
	dbd_rsp_t rsp_data;

	bit tx_jitter;
	bit rx_jitter;

	day_count_board board;

	days_between_dates_counter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// observe both sides at the rising edge
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) board.note_dates(req_data);
		if (arst_n && rsp_valid && !rsp_stall) board.check_count(rsp_data);
	end

	// response back-pressure in runs of random length
	initial begin
		int unsigned hold;
		hold      = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!rx_jitter) begin
				rsp_stall = 1'b0;
				hold      = 0;
			end else if (hold > 0) begin
				hold--;
			end else begin
				rsp_stall = ($urandom_range(0, 9) < 4);
				hold      = idle_len();
			end
		end
	end

	// watchdog on cycles with no transfer
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb NOT OK");
		$finish;
	end

	// one request transfer, with an optional gap before it
	task automatic send_dates(input dbd_req_t r);
		int unsigned gap;
		gap = tx_jitter ? idle_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		req_data  = r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// stop sending until every expected result is back
	task automatic drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned n;
		board     = new();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, leap rules, clamping, order error, saturation
		send_dates(date_pair(2000, 1, 1, 2000, 1, 1));
		send_dates(date_pair(0, 1, 1, 16383, 12, 31));
		send_dates(date_pair(16383, 15, 31, 0, 0, 0));
		send_dates(date_pair(1, 1, 1, 9999, 12, 31));
		send_dates(date_pair(1900, 2, 28, 1900, 3, 1));
		send_dates(date_pair(2000, 2, 28, 2000, 3, 1));
		send_dates(date_pair(2004, 2, 29, 2004, 3, 1));
		send_dates(date_pair(2100, 2, 29, 2100, 3, 1));
		send_dates(date_pair(0, 2, 29, 0, 3, 1));
		send_dates(date_pair(2001, 0, 0, 2001, 1, 1));
		send_dates(date_pair(2021, 4, 31, 2021, 5, 1));
		send_dates(date_pair(2001, 2, 30, 2001, 3, 1));
		send_dates(date_pair(2000, 13, 5, 2000, 12, 5));
		send_dates(date_pair(2000, 14, 31, 2001, 15, 0));
		send_dates(date_pair(1999, 12, 31, 2000, 1, 1));
		send_dates(date_pair(2020, 5, 2, 2020, 5, 1));
		send_dates(date_pair(9999, 12, 31, 1, 1, 1));
		send_dates(date_pair(14'h2aaa, 4'ha, 5'h15, 14'h1555, 4'h5, 5'h0a));
		send_dates(date_pair(14'h1555, 4'h5, 5'h0a, 14'h2aaa, 4'ha, 5'h15));
		send_dates(date_pair(16383, 12, 31, 16383, 12, 31));
		drain();

		// random pairs with idling on both sides
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 40) drain();
			// a stretch at full rate
			if (n == 60) begin
				tx_jitter = 1'b0;
				rx_jitter = 1'b0;
			end
			if (n == 75) begin
				tx_jitter = 1'b1;
				rx_jitter = 1'b1;
			end
			send_dates(random_dates());
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			$display("%0t %0d expected results never arrived", $time, board.pending());
			board.fails++;
		end
		if (board.fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
